### design/xkb_pkg.sv
`timescale 1ns / 1ps

package xkb_pkg;

    // Configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_MODE       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_LENGTH = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_WORD_0 = 3'd2;

    // Mode and item function codes
    localparam logic MODE_ENCODE = 1'b0;
    localparam logic MODE_DECODE = 1'b1;
    localparam logic FUNC_DATA   = 1'b0;
    localparam logic FUNC_END    = 1'b1;

    localparam logic [7:0] CHAR_PAD = 8'h3D;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;

    typedef struct packed {
        logic       mode;
        logic [5:0] key_length;
    } t_cfg;

    // One accepted item's worth of results
    typedef struct packed {
        logic [3:0][7:0] data;
        logic [2:0]      count;
        logic            has_data;
        logic            last;
        logic            stopped;
    } t_desc;

    typedef struct packed {
        logic       valid;
        logic [5:0] value;
    } t_sextet;

    // Map a 6-bit value to its base64 character
    function automatic logic [7:0] b64_char(input logic [5:0] s);
        logic [7:0] c;
        if (s < 6'd26) begin
            c = 8'h41 + {2'b00, s};
        end else if (s < 6'd52) begin
            c = 8'h61 + {2'b00, s} - 8'd26;
        end else if (s < 6'd62) begin
            c = 8'h30 + {2'b00, s} - 8'd52;
        end else if (s == 6'd62) begin
            c = 8'h2B;
        end else begin
            c = 8'h2F;
        end
        return c;
    endfunction

    // Map a character back to its 6-bit value, flag it when outside the alphabet
    function automatic t_sextet b64_sextet(input logic [7:0] c);
        t_sextet r;
        r.valid = 1'b1;
        r.value = 6'd0;
        if (c >= 8'h41 && c <= 8'h5A) begin
            r.value = 6'(c - 8'h41);
        end else if (c >= 8'h61 && c <= 8'h7A) begin
            r.value = 6'(c - 8'h61 + 8'd26);
        end else if (c >= 8'h30 && c <= 8'h39) begin
            r.value = 6'(c - 8'h30 + 8'd52);
        end else if (c == 8'h2B) begin
            r.value = 6'd62;
        end else if (c == 8'h2F) begin
            r.value = 6'd63;
        end else begin
            r.valid = 1'b0;
        end
        return r;
    endfunction

endpackage

### design/xkb_front.sv
`timescale 1ns / 1ps

module xkb_front #(
    parameter int KEY_MAX_BYTES = 32
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  xkb_pkg::t_cfg                   i_cfg,
    input  logic [KEY_MAX_BYTES-1:0][7:0]   i_key,
    input  logic                            i_clear,
    input  logic                            i_valid,
    input  logic                            i_func,
    input  logic [7:0]                      i_in_byte,
    input  logic                            i_in_last,
    input  logic                            i_full,
    output logic                            o_stall,
    output logic                            o_push,
    output xkb_pkg::t_desc                  o_desc
);
    import xkb_pkg::*;

    localparam int KIW = (KEY_MAX_BYTES > 1) ? $clog2(KEY_MAX_BYTES) : 1;
    localparam logic [5:0] KEY_MAX = 6'(KEY_MAX_BYTES);

    logic [11:0]    r_acc,    n_acc;
    logic [3:0]     r_held,   n_held;
    logic [KIW-1:0] r_kidx,   n_kidx;
    logic [1:0]     r_phase,  n_phase;
    logic           r_halted, n_halted;

    logic           accept;
    logic           is_end;
    logic [5:0]     eff_len;
    logic [KIW-1:0] kidx_use;
    logic [5:0]     kidx_inc;
    logic [7:0]     key_byte;

    assign o_stall = i_full;
    assign accept  = i_valid && !i_full;
    assign is_end  = i_in_last || (i_func == FUNC_END);

    // Clamp key length and pick the current key byte
    always_comb begin
        if (i_cfg.key_length == 6'd0) begin
            eff_len = 6'd1;
        end else if (i_cfg.key_length > KEY_MAX) begin
            eff_len = KEY_MAX;
        end else begin
            eff_len = i_cfg.key_length;
        end
        kidx_use = (6'(r_kidx) >= eff_len) ? '0 : r_kidx;
        kidx_inc = 6'(kidx_use) + 6'd1;
        key_byte = i_key[kidx_use];
    end

    // Classify the item and build its result group
    always_comb begin
        logic [4:0]      h;
        logic [11:0]     acc1;
        logic [2:0]      nc;
        logic [2:0]      total;
        logic [1:0]      ph;
        logic [1:0]      pads;
        logic [3:0][7:0] res;
        logic            kuse;
        logic            halt1;
        t_sextet         sx;

        h     = {1'b0, r_held};
        acc1  = r_acc;
        nc    = 3'd0;
        res   = '0;
        kuse  = 1'b0;
        halt1 = r_halted;
        sx    = b64_sextet(i_in_byte);
        ph    = 2'd0;
        pads  = 2'd0;

        if (i_cfg.mode == MODE_ENCODE) begin
            if (i_func == FUNC_DATA) begin
                acc1 = {r_acc[3:0], i_in_byte ^ key_byte};
                h    = {1'b0, r_held} + 5'd8;
                kuse = 1'b1;
                if (h >= 5'd6 && h <= 5'd12) begin
                    res[0] = b64_char(6'(acc1 >> (h - 5'd6)));
                    h      = h - 5'd6;
                    nc     = 3'd1;
                    if (h >= 5'd6) begin
                        res[1] = b64_char(6'(acc1 >> (h - 5'd6)));
                        h      = h - 5'd6;
                        nc     = 3'd2;
                    end
                end
            end
            if (is_end) begin
                // flush leftover bits as one more character
                if (h > 5'd0 && h < 5'd6) begin
                    res[nc[1:0]] = b64_char(6'(acc1 << (5'd6 - h)));
                    nc           = nc + 3'd1;
                end
                ph   = r_phase + nc[1:0];
                pads = 2'(3'd4 - {1'b0, ph});
            end
        end else begin
            if (i_func == FUNC_DATA && !r_halted) begin
                if (!sx.valid) begin
                    halt1 = 1'b1;
                end else begin
                    acc1 = {r_acc[5:0], sx.value};
                    h    = {1'b0, r_held} + 5'd6;
                    if (h >= 5'd8 && h <= 5'd12) begin
                        res[0] = 8'(acc1 >> (h - 5'd8)) ^ key_byte;
                        kuse   = 1'b1;
                        nc     = 3'd1;
                        h      = h - 5'd8;
                    end else if (h > 5'd12) begin
                        h = 5'd0;
                    end
                end
            end
        end

        // Pad with '=' up to four results
        total = nc + {1'b0, pads};
        if (total > 3'd4) begin
            total = 3'd4;
        end
        for (int k = 0; k < 4; k++) begin
            if (3'(k) >= nc && 3'(k) < total) begin
                res[k] = CHAR_PAD;
            end
        end

        o_desc.data     = res;
        o_desc.last     = is_end;
        o_desc.stopped  = is_end && (i_cfg.mode == MODE_DECODE) && halt1;
        o_desc.has_data = (total != 3'd0);
        o_desc.count    = (total == 3'd0) ? 3'd1 : total;
        o_push          = accept && ((total != 3'd0) || is_end);

        n_acc    = acc1;
        n_held   = 4'(h);
        n_phase  = r_phase + nc[1:0];
        n_halted = halt1;
        n_kidx   = r_kidx;
        if (kuse) begin
            n_kidx = (kidx_inc >= eff_len) ? '0 : KIW'(kidx_inc);
        end
    end

    // Hold message state, clear it at each end and on a mode write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_acc    <= '0;
            r_held   <= '0;
            r_kidx   <= '0;
            r_phase  <= '0;
            r_halted <= 1'b0;
        end else if (accept) begin
            if (is_end) begin
                r_acc    <= '0;
                r_held   <= '0;
                r_kidx   <= '0;
                r_phase  <= '0;
                r_halted <= 1'b0;
            end else begin
                r_acc    <= n_acc;
                r_held   <= n_held;
                r_kidx   <= n_kidx;
                r_phase  <= n_phase;
                r_halted <= n_halted;
            end
        end
    end

`ifndef SYNTHESIS
    a_halt_decode_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_halted |-> (i_cfg.mode == MODE_DECODE))
        else $error("halted flag set in encode mode");
    a_held_even: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_held[0])
        else $error("odd number of held bits");
`endif

endmodule

### design/xkb_queue.sv
`timescale 1ns / 1ps

module xkb_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  xkb_pkg::t_desc  i_desc,
    input  logic            i_pop,
    output xkb_pkg::t_desc  o_head,
    output logic            o_empty,
    output logic            o_full
);
    import xkb_pkg::*;

    t_desc             r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr;
    logic [QPTR_W-1:0] r_rd;
    logic [QPTR_W:0]   r_count;

    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == (QPTR_W + 1)'(QUEUE_DEPTH));
    assign o_head  = r_mem[r_rd];

    // Store the pushed group
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_desc;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("push into full queue");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty)
        else $error("pop from empty queue");
`endif

endmodule

### design/xkb_back.sv
`timescale 1ns / 1ps

module xkb_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  xkb_pkg::t_desc  i_head,
    input  logic            i_empty,
    output logic            o_pop,
    output logic            o_valid,
    input  logic            i_stall,
    output logic [7:0]      o_out_byte,
    output logic            o_out_has_data,
    output logic            o_out_last,
    output logic            o_out_stopped
);
    import xkb_pkg::*;

    logic       r_valid;
    logic [1:0] r_sub;
    logic [7:0] r_byte;
    logic       r_has_data;
    logic       r_last;
    logic       r_stopped;

    logic       load;
    logic       last_sub;

    assign load     = !r_valid || !i_stall;
    assign last_sub = ({1'b0, r_sub} == (i_head.count - 3'd1));
    assign o_pop    = load && !i_empty && last_sub;

    // Step through the head group, one result per cycle while the output is not stalled
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_sub   <= '0;
        end else if (load) begin
            r_valid <= !i_empty;
            if (!i_empty) begin
                r_sub <= last_sub ? 2'd0 : r_sub + 2'd1;
            end
        end
    end

    // Load the output register
    always_ff @(posedge i_clk) begin
        if (load && !i_empty) begin
            r_byte     <= i_head.data[r_sub];
            r_has_data <= i_head.has_data;
            r_last     <= i_head.last && last_sub;
            r_stopped  <= i_head.stopped && last_sub;
        end
    end

    assign o_valid        = r_valid;
    assign o_out_byte     = r_byte;
    assign o_out_has_data = r_has_data;
    assign o_out_last     = r_last;
    assign o_out_stopped  = r_stopped;

`ifndef SYNTHESIS
    a_bare_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !r_has_data) |-> (r_last && r_byte == 8'd0))
        else $error("bare result that is not the message end");
`endif

endmodule

### design/xor_key_base64_codec.sv
// Byte-stream codec: encode XORs each byte with a repeating key of 1 to KEY_MAX_BYTES bytes and
// packs the result into base64 characters, padding with '=' at message end; decode maps base64
// characters back to bytes and XORs them with the key, stopping at the first character outside
// the alphabet. Every message closes with a result that has out_last set (a bare one with
// out_has_data low if nothing else is due). The front takes one item per cycle while its
// four-entry group queue has room; the back sends one result per cycle while i_stall is low,
// so an item drains at the pace of the results it makes (encode makes 4/3 results per byte on
// average, decode at most one, a closing item up to four). Configuration writes are always
// ready and take effect next cycle; writing the mode register clears the message in progress.
`timescale 1ns / 1ps

module xor_key_base64_codec #(
    parameter int KEY_MAX_BYTES = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_func,
    input  logic [7:0]  i_in_byte,
    input  logic        i_in_last,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_out_byte,
    output logic        o_out_has_data,
    output logic        o_out_last,
    output logic        o_out_stopped
);
    import xkb_pkg::*;

    logic                          r_mode;
    logic [5:0]                    r_key_length;
    logic [KEY_MAX_BYTES-1:0][7:0] r_key;

    t_cfg  cfg;
    logic  cfg_we;
    logic  cfg_clear;
    logic  push;
    logic  pop;
    logic  empty;
    logic  full;
    t_desc desc;
    t_desc head;

    assign o_cfg_ready = 1'b1;
    assign cfg_we      = i_cfg_valid && o_cfg_ready;
    assign cfg_clear   = cfg_we && (i_cfg_index == CFG_MODE);
    assign cfg.mode       = r_mode;
    assign cfg.key_length = r_key_length;

    // Hold configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= MODE_ENCODE;
            r_key_length <= 6'd1;
            r_key        <= '0;
        end else if (cfg_we) begin
            case (i_cfg_index)
                CFG_MODE:       r_mode       <= i_cfg_data[0];
                CFG_KEY_LENGTH: r_key_length <= i_cfg_data[5:0];
                default: ;
            endcase
            for (int b = 0; b < KEY_MAX_BYTES; b++) begin
                if (i_cfg_index == CFG_KEY_WORD_0 + 3'(b / 8)) begin
                    r_key[b] <= i_cfg_data[8 * (b % 8) +: 8];
                end
            end
        end
    end

    xkb_front #(
        .KEY_MAX_BYTES (KEY_MAX_BYTES)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (cfg),
        .i_key     (r_key),
        .i_clear   (cfg_clear),
        .i_valid   (i_valid),
        .i_func    (i_func),
        .i_in_byte (i_in_byte),
        .i_in_last (i_in_last),
        .i_full    (full),
        .o_stall   (o_stall),
        .o_push    (push),
        .o_desc    (desc)
    );

    xkb_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_desc  (desc),
        .i_pop   (pop),
        .o_head  (head),
        .o_empty (empty),
        .o_full  (full)
    );

    xkb_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_head         (head),
        .i_empty        (empty),
        .o_pop          (pop),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_out_byte     (o_out_byte),
        .o_out_has_data (o_out_has_data),
        .o_out_last     (o_out_last),
        .o_out_stopped  (o_out_stopped)
    );

endmodule
